/* sv/sli_pkg.sv */
// shared constants and controller/datapath interface types for the sorted insert core
`timescale 1ns / 1ps

package sli_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]  count_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic insert;   // place the incoming value into the table
        logic shift;    // drop the head entry, everything moves down one place
    } sli_cmd_t;

    // status from the datapath back to the controller
    typedef struct packed {
        logic empty;
        logic last;     // exactly one entry left
    } sli_status_t;

endpackage

/* sv/sorted_list_insert_core.sv */
// top level of the sorted insert core: controller plus insertion cell datapath
//
// input stream: each word carries a signed 32-bit value in tdata; tlast set
// means flush. the value is inserted into a sorted table of 64 entries (one
// compare cell per entry), after any stored entries equal to it.
// a value arriving at a full table is dropped and the overflow flag is set.
// on a flush word the insert happens first, then the table streams out on the
// output side in ascending order, one word per cycle, tlast on the final
// entry and tuser carrying the overflow flag on every word of the run.
// after the last word is taken the table and the flag are empty again.
// after a plain insert the input is ready for the next word; a flush is
// followed by the head-of-table shift readout of every stored entry. input
// tready is low during readout. output words come straight from the head
// cell, so a stall on m_axis_tready simply holds the current entry.
// reset (rst_n low, asynchronous) empties the table and clears the flag;
// no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_list_insert_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,   // is_last
    output logic        m_axis_tuser    // [0] dropped_any
);
    import sli_pkg::*;

    sli_cmd_t    cmd;
    sli_status_t status;
    data_t       head_value;
    logic        dropped;

    sli_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sli_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_value   (s_axis_tdata),
        .status     (status),
        .head_value (head_value),
        .dropped    (dropped)
    );

    assign m_axis_tdata = head_value;
    assign m_axis_tlast = status.last;
    assign m_axis_tuser = dropped;

endmodule

/* sv/sli_datapath.sv */
// insertion cell chain holding the sorted table, entry count and overflow flag
`timescale 1ns / 1ps

module sli_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sli_pkg::sli_cmd_t    cmd,
    input  sli_pkg::data_t       in_value,
    output sli_pkg::sli_status_t status,
    output sli_pkg::data_t       head_value,
    output logic                 dropped
);
    import sli_pkg::*;

    data_t  entry_reg  [CAPACITY];
    data_t  entry_next [CAPACITY];
    logic   gt         [CAPACITY];
    count_t count_reg;
    count_t count_next;
    logic   ovf_reg;
    logic   ovf_next;
    logic   full;

    assign full = (count_reg == count_t'(CAPACITY));

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            data_t from_below;
            data_t from_above;

            // empty slots count as greater, so a value above every stored entry lands at the first free slot
            assign gt[i] = (count_t'(i) >= count_reg) ||
                           ($signed(entry_reg[i]) > $signed(in_value));

            if (i == 0)
            begin : g_first
                assign from_below = in_value;
            end
            else
            begin : g_rest
                assign from_below = gt[i-1] ? entry_reg[i-1] : in_value;
            end

            if (i == CAPACITY - 1)
            begin : g_top
                assign from_above = entry_reg[i];
            end
            else
            begin : g_mid
                assign from_above = entry_reg[i+1];
            end

            always_comb
            begin
                entry_next[i] = entry_reg[i];
                if (cmd.insert && !full)
                begin
                    if (gt[i])
                    begin
                        entry_next[i] = from_below;
                    end
                end
                else if (cmd.shift)
                begin
                    entry_next[i] = from_above;
                end
            end

            always_ff @(posedge clk)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + count_t'(1);
            end
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - count_t'(1);
            if (count_reg == count_t'(1))
            begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.empty = (count_reg == '0);
    assign status.last  = (count_reg == count_t'(1));
    assign head_value   = entry_reg[0];
    assign dropped      = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("entry count above capacity");

    a_drop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && full) |=> ovf_reg && (count_reg == count_t'(CAPACITY)))
        else $error("drop on full table did not set overflow");

    a_shift_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && !cmd.insert) |=> (count_reg == $past(count_reg) - count_t'(1)))
        else $error("readout shift did not decrement count");

endmodule

/* sv/sli_ctrl.sv */
// controller: idle/insert and readout sequencing
`timescale 1ns / 1ps

module sli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  sli_pkg::sli_status_t status,
    output sli_pkg::sli_cmd_t    cmd
);
    import sli_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic in_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_READ);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign cmd.insert = in_fire;
    assign cmd.shift  = (state_reg == ST_READ) && m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && s_axis_tlast)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (m_axis_tready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !status.empty)
        else $error("readout with an empty table");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && cmd.shift))
        else $error("insert and shift in the same cycle");

    a_flush_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (state_reg == ST_READ))
        else $error("flush word did not start readout");

endmodule

/* test/sorted_list_insert_checker.sv */
// checker for the sorted insert core: tracks the table, predicts readout words and compares them
`timescale 1ns / 1ps

module sorted_list_insert_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  sli_pkg::data_t s_tdata,
    input  logic           s_tlast,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  sli_pkg::data_t m_tdata,
    input  logic           m_tlast,
    input  logic           m_tuser,
    output int             mismatches,
    output int             pending
);
    import sli_pkg::*;

    typedef struct {
        data_t value;
        logic  is_last;
        logic  dropped_any;
    } readout_word_t;

    data_t         entries_q[$];
    logic          overflow_seen = 1'b0;
    readout_word_t readout_q[$];

    // new value goes after every stored entry that is less or equal; at capacity it is dropped and overflow is noted
    function automatic void insert_sorted(input data_t raw);
        int pos = 0;
        if (entries_q.size() >= CAPACITY)
        begin
            overflow_seen = 1'b1;
            return;
        end
        while (pos < entries_q.size() && $signed(entries_q[pos]) <= $signed(raw))
            pos++;
        entries_q.insert(pos, raw);
    endfunction

    function automatic void queue_readout();
        readout_word_t w;
        for (int k = 0; k < entries_q.size(); k++)
        begin
            w.value       = entries_q[k];
            w.is_last     = (k == entries_q.size() - 1);
            w.dropped_any = overflow_seen;
            readout_q.push_back(w);
        end
        entries_q.delete();
        overflow_seen = 1'b0;
    endfunction

    always @(posedge clk)
    begin : watch
        readout_word_t exp_w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (readout_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual %0d last %b drop %b",
                             $time, $signed(m_tdata), m_tlast, m_tuser);
                end
                else
                begin
                    exp_w = readout_q.pop_front();
                    if (m_tdata !== exp_w.value || m_tlast !== exp_w.is_last ||
                        m_tuser !== exp_w.dropped_any)
                    begin
                        mismatches++;
                        $display("%0t: expected %0d last %b drop %b, actual %0d last %b drop %b",
                                 $time, $signed(exp_w.value), exp_w.is_last,
                                 exp_w.dropped_any, $signed(m_tdata), m_tlast, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                insert_sorted(s_tdata);
                if (s_tlast)
                    queue_readout();
            end
            pending = readout_q.size();
        end
    end

endmodule

/* test/sorted_list_insert_core_test.sv */
// testbench top for the sorted insert core: stimulus, output stalls and verdict
`timescale 1ns / 1ps

module sorted_list_insert_core_test;
    import sli_pkg::*;

    localparam int ITEM_GOAL = 180;

    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    data_t s_axis_tdata  = '0;
    logic  s_axis_tlast  = 1'b0;
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    data_t m_axis_tdata;
    logic  m_axis_tlast;
    logic  m_axis_tuser;

    logic  idle_on = 1'b1;
    int    mismatches;
    int    pending;

    always #4 clk = ~clk;

    sorted_list_insert_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_list_insert_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast),
        .m_tuser    (m_axis_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // output side stalls at random unless in a calm stretch
    always @(negedge clk)
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 9);

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_word(input data_t word_value, input logic flush_bit);
        if (idle_on && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word_value;
        s_axis_tlast  <= flush_bit;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // hold the input until every readout word has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(3))
            0: pick_value = data_t'($urandom_range(16)) - data_t'(8);
            1:
            begin
                case ($urandom_range(3))
                    0: pick_value = 32'h8000_0000;
                    1: pick_value = 32'h7fff_ffff;
                    2: pick_value = 32'h0000_0000;
                    default: pick_value = 32'hffff_ffff;
                endcase
            end
            default: pick_value = $urandom;
        endcase
    endfunction

    initial
    begin
        int sent;
        int run_idx;
        int run_len;
        sent    = 0;
        run_idx = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-entry readouts at both extremes
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h7fff_ffff, 1'b1);
        // mixed signs, extremes and duplicates
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_0001, 1'b0);
        push_word(32'h7fff_ffff, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hffff_ffff, 1'b1);
        // equal values
        push_word(32'd42, 1'b0);
        push_word(32'd42, 1'b0);
        push_word(32'd42, 1'b1);
        // descending order
        for (int v = 5; v >= 1; v--)
            push_word(data_t'(v), v == 1);
        drain();

        while (sent < ITEM_GOAL)
        begin
            // first run overfills the table so drops get seen early
            if (run_idx == 0)
                run_len = CAPACITY + 3;
            else if ($urandom_range(9) == 0)
                run_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            else
                run_len = $urandom_range(1, 12);
            idle_on <= !(run_idx >= 3 && run_idx < 8);
            for (int i = 0; i < run_len; i++)
                push_word(pick_value(), i == run_len - 1);
            sent += run_len;
            run_idx++;
            if ($urandom_range(7) == 0)
                drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/sli_pkg.sv
sv/sli_datapath.sv
sv/sli_ctrl.sv
sv/sorted_list_insert_core.sv
test/sorted_list_insert_checker.sv
test/sorted_list_insert_core_test.sv
